// ----- src/ultrasonic_echo_ranging_core_macros.svh -----
// Assertion macros for the ultrasonic echo ranging core.
// Every macro assumes a clock named clk and an active-low reset named arst_n in scope.
`ifndef ULTRASONIC_ECHO_RANGING_CORE_MACROS_SVH
`define ULTRASONIC_ECHO_RANGING_CORE_MACROS_SVH

// Condition that must hold at every clock edge once out of reset
`define UER_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication
`define UER_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication
`define UER_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- src/uer_pkg.sv -----
// Shared widths, reset values, register indexes and divider constants
// for the ultrasonic echo ranging core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

	// Field and state widths
	localparam int TICK_W     = 8;
	localparam int US_W       = 16;
	localparam int SUM_W      = 19;
	localparam int IDX_W      = 3;
	localparam int DIST_W     = 14;
	localparam int FRAME_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	// Measurements averaged per result
	localparam int SAMPLES_DEF = 5;

	// Register reset values
	localparam logic [TICK_W-1:0] TRIGGER_TICKS_RST = 8'd20;
	localparam logic [TICK_W-1:0] GAP_TICKS_RST     = 8'd10;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS     = 1'b1;

	// sum*10/(58*N) == sum*5/(29*N): scaled dividend and divisor base
	localparam int US_PER_HALF_CM = 29;
	localparam int DIVIDEND_W     = SUM_W + 3;     // holds sum*5
	localparam int DIV_W          = 8;             // 29*7 = 203 max
	localparam int RECIP_SHIFT    = DIVIDEND_W;    // keeps estimate within one of exact
	localparam int RECIP_W        = 18;            // floor(2^22/29) < 2^18
	localparam int PROD_W         = DIVIDEND_W + RECIP_W;

endpackage

`default_nettype wire

// ----- src/ultrasonic_echo_ranging_core.sv -----
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_stall    echo_level (one item per microsecond tick)
// out       out  out_valid/out_stall  trigger_out, distance_mm, distance_valid, frame_count
// cfg       in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per clock while in_stall is low. A result passes through the three register
// stages in order: tick state update, reciprocal multiply, remainder correction.
// arst_n clears sequencer state, counters, registers to defaults and all stage valids.
// A stalled output backs up stage by stage; in_stall rises only when every stage is full.
// Depends on uer_pkg and ultrasonic_echo_ranging_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "ultrasonic_echo_ranging_core_macros.svh"

module ultrasonic_echo_ranging_core
	import uer_pkg::*;
#(
	parameter int SAMPLES = SAMPLES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// tick input
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic                  echo_level,
	// result output
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       trigger_out,
	output logic [DIST_W-1:0]          distance_mm,
	output logic                       distance_valid,
	output logic [FRAME_W-1:0]         frame_count,
	// register writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		PH_TRIG,
		PH_WAIT,
		PH_HIGH,
		PH_GAP
	} phase_t;

	localparam int                 DIVISOR  = US_PER_HALF_CM * SAMPLES;
	localparam logic [DIV_W-1:0]   DIV_C    = DIV_W'(DIVISOR);
	localparam logic [RECIP_W-1:0] RECIP_C  = RECIP_W'((64'd1 << RECIP_SHIFT) / DIVISOR);
	localparam logic [IDX_W-1:0]   SMP_CNT  = IDX_W'(SAMPLES);

	// configuration registers
	logic [TICK_W-1:0] trigger_ticks_q, gap_ticks_q;

	// sequencer state
	phase_t             phase_q, phase_d;
	logic [TICK_W-1:0]  phase_ticks_q, phase_ticks_d;
	logic [US_W-1:0]    echo_us_q, echo_us_d;
	logic [SUM_W-1:0]   echo_sum_q, echo_sum_d;
	logic [IDX_W-1:0]   sample_idx_q, sample_idx_d;
	logic [FRAME_W-1:0] edge_count_q, edge_count_d;

	// tick logic outputs
	logic              trig_d, fin_d;
	logic [SUM_W-1:0]  sum_done;
	logic [TICK_W-1:0] ticks_inc;
	logic [IDX_W-1:0]  idx_inc;

	// stage 1: tick result
	logic               v_s1, trig_s1, fin_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic [FRAME_W-1:0] edge_s1;

	// stage 2: quotient estimate
	logic               v_s2, trig_s2, fin_s2;
	logic [DIVIDEND_W-1:0] x_s2;
	logic [DIST_W-1:0]  q0_s2;
	logic [FRAME_W-1:0] edge_s2;

	// stage 3: output register
	logic               v_s3, trig_s3, dvalid_s3;
	logic [DIST_W-1:0]  dist_s3;
	logic [FRAME_W-1:0] frame_s3;

	logic en_s1, en_s2, en_s3, accept;
	logic [DIVIDEND_W-1:0] dividend;
	logic [PROD_W-1:0]     prod;
	logic [DIVIDEND_W-1:0] qd, rem;
	logic [DIST_W-1:0]     q_fix;

	// stage enables: a stage moves when empty or when its successor moves
	assign en_s3    = !v_s3 || !out_stall;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign accept   = in_valid && en_s1;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ticks_q <= TRIGGER_TICKS_RST;
			gap_ticks_q     <= GAP_TICKS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TRIGGER_TICKS: trigger_ticks_q <= cfg_data;
				REG_GAP_TICKS:     gap_ticks_q     <= cfg_data;
			endcase
		end
	end

	// per-tick sequencer: trigger, wait for rise, time echo, gap
	always_comb begin
		phase_d       = phase_q;
		phase_ticks_d = phase_ticks_q;
		echo_us_d     = echo_us_q;
		echo_sum_d    = echo_sum_q;
		sample_idx_d  = sample_idx_q;
		edge_count_d  = edge_count_q;
		trig_d        = 1'b0;
		fin_d         = 1'b0;
		ticks_inc     = phase_ticks_q + 8'd1;
		idx_inc       = sample_idx_q + 3'd1;
		sum_done      = echo_sum_q + SUM_W'(echo_us_q);
		unique case (phase_q)
			PH_TRIG: begin
				trig_d = 1'b1;
				// width 0 acts as 1: any count is >= 0
				if (ticks_inc == '0 || ticks_inc >= trigger_ticks_q) begin
					phase_d       = PH_WAIT;
					phase_ticks_d = '0;
				end else begin
					phase_ticks_d = ticks_inc;
				end
			end
			PH_WAIT: begin
				// rising tick counts as first high microsecond
				if (echo_level) begin
					edge_count_d = edge_count_q + 16'd1;
					echo_us_d    = 16'd1;
					phase_d      = PH_HIGH;
				end
			end
			PH_HIGH: begin
				if (echo_level) begin
					if (echo_us_q != '1)
						echo_us_d = echo_us_q + 16'd1;
				end else begin
					echo_us_d     = '0;
					phase_ticks_d = '0;
					phase_d       = (gap_ticks_q == '0) ? PH_TRIG : PH_GAP;
					if (idx_inc >= SMP_CNT) begin
						fin_d        = 1'b1;
						echo_sum_d   = '0;
						sample_idx_d = '0;
					end else begin
						echo_sum_d   = sum_done;
						sample_idx_d = idx_inc;
					end
				end
			end
			PH_GAP: begin
				if (ticks_inc == '0 || ticks_inc >= gap_ticks_q) begin
					phase_d       = PH_TRIG;
					phase_ticks_d = '0;
				end else begin
					phase_ticks_d = ticks_inc;
				end
			end
		endcase
	end

	// sequencer state and stage 1, updated on each transfer in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_TRIG;
			phase_ticks_q <= '0;
			echo_us_q     <= '0;
			echo_sum_q    <= '0;
			sample_idx_q  <= '0;
			edge_count_q  <= '0;
			v_s1          <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= accept;
			if (accept) begin
				phase_q       <= phase_d;
				phase_ticks_q <= phase_ticks_d;
				echo_us_q     <= echo_us_d;
				echo_sum_q    <= echo_sum_d;
				sample_idx_q  <= sample_idx_d;
				edge_count_q  <= edge_count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trig_s1 <= trig_d;
			fin_s1  <= fin_d;
			sum_s1  <= sum_done;
			edge_s1 <= edge_count_d;
		end
	end

	// stage 2: dividend = sum*5, estimate = floor(dividend*recip / 2^k), low by at most one
	assign dividend = (DIVIDEND_W'(sum_s1) << 2) + DIVIDEND_W'(sum_s1);
	assign prod     = PROD_W'(dividend) * PROD_W'(RECIP_C);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			trig_s2 <= trig_s1;
			fin_s2  <= fin_s1;
			edge_s2 <= edge_s1;
			x_s2    <= dividend;
			q0_s2   <= prod[RECIP_SHIFT +: DIST_W];
		end
	end

	// stage 3: one remainder check fixes the estimate
	assign qd    = DIVIDEND_W'(q0_s2) * DIVIDEND_W'(DIV_C);
	assign rem   = x_s2 - qd;
	assign q_fix = (rem >= DIVIDEND_W'(DIV_C)) ? q0_s2 + 14'd1 : q0_s2;

	// output register; dist_s3 doubles as the held last distance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3      <= 1'b0;
			trig_s3   <= 1'b0;
			dvalid_s3 <= 1'b0;
			dist_s3   <= '0;
			frame_s3  <= '0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
			if (v_s2) begin
				trig_s3   <= trig_s2;
				dvalid_s3 <= fin_s2;
				frame_s3  <= edge_s2;
				if (fin_s2)
					dist_s3 <= q_fix;
			end
		end
	end

	assign out_valid      = v_s3;
	assign trigger_out    = trig_s3;
	assign distance_mm    = dist_s3;
	assign distance_valid = dvalid_s3;
	assign frame_count    = frame_s3;

	// checks
	`UER_ASSERT_ALWAYS(a_idx_below_samples, sample_idx_q < SMP_CNT, "sample index at SAMPLES")
	`UER_ASSERT_IMPL(a_us_clear_off_high, phase_q != PH_HIGH, echo_us_q == '0, "echo_us not clear")
	`UER_ASSERT_IMPL(a_rem_in_range, v_s2 && fin_s2, rem < (DIVIDEND_W'(DIV_C) << 1), "bad estimate")
	`UER_ASSERT_IMPL(a_stall_only_full, in_stall, v_s1 && v_s2 && v_s3, "stall with empty stage")

endmodule

`default_nettype wire

// ----- sim/ultrasonic_echo_ranging_core_tb.sv -----
// Self-checking testbench for ultrasonic_echo_ranging_core: a scoreboard class predicts
// every tick result, plain tasks drive ticks and register writes, and a receiver process drives output stalls.
// Depends on uer_pkg and the core RTL.
`timescale 1ns / 1ps

module ultrasonic_echo_ranging_core_tb;
	import uer_pkg::*;

	localparam int N_AVG                = SAMPLES_DEF;
	localparam int PIPE_LAT             = 3;
	localparam int ROUND_TRIP_US_PER_CM = 58;
	localparam int MM_PER_CM            = 10;
	localparam int DIST_MAX             = (1 << DIST_W) - 1;
	localparam int US_MAX               = (1 << US_W) - 1;
	localparam int LONG_ECHO_US         = 30;
	localparam int RAND_ITEMS           = 1000;
	localparam int PHASE_ITEMS          = 180;
	localparam int HOLD_OFF_CYCLES      = 400;
	localparam int SHOWN_MISMATCHES     = 10;
	localparam int unsigned CYCLE_LIMIT = 200_000;

	typedef enum logic [1:0] {
		PH_TRIGGER,
		PH_WAIT_RISE,
		PH_ECHO_HIGH,
		PH_GAP
	} meas_phase_e;

	typedef enum int {
		RX_OPEN,
		RX_LIGHT,
		RX_PERIODIC,
		RX_HEAVY
	} rx_mode_e;

	typedef struct packed {
		logic               trigger;
		logic [DIST_W-1:0]  distance;
		logic               dist_valid;
		logic [FRAME_W-1:0] frames;
	} tick_result_t;

	// Ranging predictor plus queue of expected tick results
	class ranging_scoreboard;
		logic [TICK_W-1:0]  trig_len;
		logic [TICK_W-1:0]  gap_len;
		meas_phase_e        phase;
		logic [TICK_W-1:0]  phase_ticks;
		logic [US_W-1:0]    echo_us;
		logic [SUM_W-1:0]   echo_sum;
		logic [IDX_W-1:0]   sample_idx;
		logic [DIST_W-1:0]  last_dist;
		logic [FRAME_W-1:0] rises;
		tick_result_t       expected_q[$];
		int                 failures;
		int                 checked;
		int                 averages;
		int                 max_dist;

		function new();
			trig_len    = TRIGGER_TICKS_RST;
			gap_len     = GAP_TICKS_RST;
			phase       = PH_TRIGGER;
			phase_ticks = '0;
			echo_us     = '0;
			echo_sum    = '0;
			sample_idx  = '0;
			last_dist   = '0;
			rises       = '0;
			failures    = 0;
			checked     = 0;
			averages    = 0;
			max_dist    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_TRIGGER_TICKS)
				trig_len = val;
			else if (idx == REG_GAP_TICKS)
				gap_len = val;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Advance one microsecond tick and queue the result it produces
		function void note_tick(logic echo);
			tick_result_t r;
			logic [31:0]  quot;
			r.trigger    = 1'b0;
			r.dist_valid = 1'b0;
			case (phase)
				PH_TRIGGER: begin
					r.trigger   = 1'b1;
					phase_ticks = phase_ticks + 1'b1;
					if (phase_ticks == '0 || phase_ticks >= trig_len) begin
						phase       = PH_WAIT_RISE;
						phase_ticks = '0;
					end
				end
				PH_WAIT_RISE: begin
					// rising tick counts as the first high microsecond
					if (echo) begin
						rises   = rises + 1'b1;
						echo_us = US_W'(1);
						phase   = PH_ECHO_HIGH;
					end
				end
				PH_ECHO_HIGH: begin
					if (echo) begin
						if (echo_us != US_MAX[US_W-1:0])
							echo_us = echo_us + 1'b1;
					end else begin
						// falling tick closes the measurement
						echo_sum   = echo_sum + SUM_W'(echo_us);
						echo_us    = '0;
						sample_idx = sample_idx + 1'b1;
						if (sample_idx >= N_AVG) begin
							quot = (32'(echo_sum) * MM_PER_CM) / (ROUND_TRIP_US_PER_CM * N_AVG);
							if (quot > DIST_MAX)
								quot = DIST_MAX;
							last_dist    = quot[DIST_W-1:0];
							r.dist_valid = 1'b1;
							echo_sum     = '0;
							sample_idx   = '0;
							averages++;
							if (int'(quot) > max_dist)
								max_dist = int'(quot);
						end
						phase_ticks = '0;
						phase       = (gap_len == '0) ? PH_TRIGGER : PH_GAP;
					end
				end
				default: begin
					phase_ticks = phase_ticks + 1'b1;
					if (phase_ticks == '0 || phase_ticks >= gap_len) begin
						phase       = PH_TRIGGER;
						phase_ticks = '0;
					end
				end
			endcase
			r.distance = last_dist;
			r.frames   = rises;
			expected_q.push_back(r);
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(tick_result_t got);
			tick_result_t exp_r;
			checked++;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= SHOWN_MISMATCHES)
					$display("result %0d arrived with nothing expected", checked);
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.trigger !== exp_r.trigger || got.distance !== exp_r.distance ||
					got.dist_valid !== exp_r.dist_valid || got.frames !== exp_r.frames) begin
				failures++;
				if (failures <= SHOWN_MISMATCHES)
					$display({"mismatch at result %0d: expected trig=%0b dist=%0d valid=%0b ",
						"frames=%0d, got trig=%0b dist=%0d valid=%0b frames=%0d"},
						checked, exp_r.trigger, exp_r.distance, exp_r.dist_valid, exp_r.frames,
						got.trigger, got.distance, got.dist_valid, got.frames);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic                  echo_level = 1'b0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic                  trigger_out;
	logic [DIST_W-1:0]     distance_mm;
	logic                  distance_valid;
	logic [FRAME_W-1:0]    frame_count;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	ranging_scoreboard sb = new();

	int unsigned cycle_count = 0;
	int          hold_cycles = 0;
	bit          pace_en     = 1'b1;
	bit          stall_en    = 1'b1;
	int          burst_left  = 0;
	int          high_left   = 0;
	int          ticks_sent  = 0;
	int          reg_writes  = 0;

	ultrasonic_echo_ranging_core #(
		.SAMPLES(N_AVG)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.echo_level(echo_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.trigger_out(trigger_out),
		.distance_mm(distance_mm),
		.distance_valid(distance_valid),
		.frame_count(frame_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still expected", cycle_count,
			sb.pending());
		$display("CHECKS FAILED");
		$finish;
	end

	// Output monitor: check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{trigger_out, distance_mm, distance_valid, frame_count});
	end

	// Receiver: stall pattern switches to a random mode after a run of random length; long hold-off on request
	initial begin : rx_stall_gen
		rx_mode_e mode;
		int       mode_left;
		mode      = RX_OPEN;
		mode_left = 0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = rx_mode_e'($urandom_range(3));
				mode_left = $urandom_range(8, 80);
			end
			mode_left--;
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (!stall_en) begin
				out_stall <= 1'b0;
			end else begin
				case (mode)
					RX_OPEN:     out_stall <= 1'b0;
					RX_LIGHT:    out_stall <= ($urandom_range(3) == 0);
					RX_PERIODIC: out_stall <= (mode_left % 3 == 0);
					default:     out_stall <= ($urandom_range(3) != 0);
				endcase
			end
		end
	end

	// One tick transfer; entered and left at a falling edge
	task automatic send_tick(input logic lvl);
		echo_level <= lvl;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_tick(lvl);
		ticks_sent++;
		@(negedge clk);
	endtask

	// Sender bursts with random gaps in between
	task automatic paced_send(input logic lvl);
		int gap;
		if (pace_en && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		if (burst_left > 0)
			burst_left--;
		send_tick(lvl);
	endtask

	// Stop sending and let every expected result come out
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (PIPE_LAT + 2) @(negedge clk);
	endtask

	task automatic write_regs(input logic [CFG_DATA_W-1:0] trig, input logic [CFG_DATA_W-1:0] gap);
		cfg_valid <= 1'b1;
		cfg_index <= REG_TRIGGER_TICKS;
		cfg_data  <= trig;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(REG_TRIGGER_TICKS, trig);
		@(negedge clk);
		cfg_index <= REG_GAP_TICKS;
		cfg_data  <= gap;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(REG_GAP_TICKS, gap);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes += 2;
	endtask

	// Echo shaped after the predicted phase: rises while waiting, holds for a planned
	// length, with some noise that gives spurious rises and early falls
	task automatic run_random(input int n_items);
		logic lvl;
		int   len;
		high_left = 0;
		repeat (n_items) begin
			if ($urandom_range(99) < 8) begin
				lvl = 1'($urandom_range(1));
			end else begin
				case (sb.phase)
					PH_WAIT_RISE: begin
						lvl = ($urandom_range(2) == 0);
						if (lvl) begin
							len       = ($urandom_range(9) == 0) ? $urandom_range(1, 300)
								: $urandom_range(1, 12);
							high_left = len - 1;
						end
					end
					PH_ECHO_HIGH: begin
						lvl = (high_left > 0);
						if (high_left > 0)
							high_left--;
					end
					default: lvl = 1'($urandom_range(1));
				endcase
			end
			paced_send(lvl);
		end
	endtask

	// Main sequence
	initial begin : stimulus
		int rand_start;
		int p;
		logic [CFG_DATA_W-1:0] trig;
		logic [CFG_DATA_W-1:0] gap;

		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: a few trigger ticks at reset width, then shrink the width mid phase
		repeat (3) paced_send(1'b1);
		drain_results();
		write_regs(8'd0, 8'd0);
		// zero width ends the trigger at once; 3 us echo, then four 1 us echoes, no gap
		paced_send(1'b0);
		paced_send(1'b0);
		paced_send(1'b1);
		paced_send(1'b1);
		paced_send(1'b1);
		paced_send(1'b0);
		repeat (N_AVG - 1) begin
			paced_send(1'b1);
			paced_send(1'b1);
			paced_send(1'b0);
		end
		drain_results();

		// Random phases over a spread of register settings
		rand_start = ticks_sent;
		p = 0;
		while ((p < 6 || ticks_sent - rand_start < RAND_ITEMS) && p < 60) begin
			case (p)
				0: begin trig = 8'd1;   gap = 8'd0;   end
				1: begin trig = 8'd255; gap = 8'd255; end
				2: begin trig = 8'd0;   gap = 8'd1;   end
				3: begin trig = 8'd255; gap = 8'd0;   end
				4: begin trig = 8'd2;   gap = 8'd255; end
				default: begin
					if ($urandom_range(7) == 0) begin
						trig = CFG_DATA_W'($urandom_range(0, 255));
						gap  = CFG_DATA_W'($urandom_range(0, 255));
					end else begin
						trig = CFG_DATA_W'($urandom_range(0, 9));
						gap  = CFG_DATA_W'($urandom_range(0, 9));
					end
				end
			endcase
			drain_results();
			write_regs(trig, gap);
			// receiver holds off while the sender keeps offering ticks
			if (p == 2)
				hold_cycles = HOLD_OFF_CYCLES;
			pace_en  = (p != 5);
			stall_en = (p != 5);
			run_random(PHASE_ITEMS);
			p++;
		end
		drain_results();

		// Back-to-back long echoes, as many as the samples in one average
		pace_en  = 1'b0;
		stall_en = 1'b0;
		write_regs(8'd1, 8'd0);
		for (int k = 0; k < N_AVG; k++) begin
			while (sb.phase != PH_WAIT_RISE)
				paced_send(1'b0);
			repeat (LONG_ECHO_US) paced_send(1'b1);
			paced_send(1'b0);
		end
		pace_en  = 1'b1;
		stall_en = 1'b1;
		repeat (40) paced_send(1'($urandom_range(1)));
		drain_results();
		repeat (4 * PIPE_LAT) @(negedge clk);

		$display("Run covered %0d ticks in %0d random phases, %0d register writes,",
			ticks_sent, p, reg_writes);
		$display("%0d averages (max %0d mm), %0d results checked, %0d failures",
			sb.averages, sb.max_dist, sb.checked, sb.failures);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+src
src/uer_pkg.sv
src/ultrasonic_echo_ranging_core.sv
sim/ultrasonic_echo_ranging_core_tb.sv
